[rtl/lcs_pkg.sv]
// Shared constants, types and pointer helpers for the linear convolution stream.
package lcs_pkg;

  localparam int MAX_TAPS = 32;
  localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LEN_W    = $clog2(MAX_TAPS + 1);
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = 40;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last_tap;
    logic zero;
  } mac_cmd_t;

  function automatic logic [TAP_AW-1:0] ptr_dec(input logic [TAP_AW-1:0] p);
    logic [TAP_AW-1:0] r;
    if (p == '0) begin
      r = TAP_AW'(MAX_TAPS - 1);
    end else begin
      r = p - TAP_AW'(1);
    end
    return r;
  endfunction

  function automatic logic [TAP_AW-1:0] ptr_add(input logic [TAP_AW-1:0] p,
                                                input logic [TAP_AW-1:0] k);
    logic [TAP_AW:0] s;
    s = {1'b0, p} + {1'b0, k};
    if (s >= (TAP_AW + 1)'(MAX_TAPS)) begin
      s = s - (TAP_AW + 1)'(MAX_TAPS);
    end
    return s[TAP_AW-1:0];
  endfunction

endpackage

[rtl/linear_convolution_stream_top.sv]
// Top level of the linear convolution stream: kernel store, delay line, MAC and sequencer.
//
// A coefficient beat (operation 0) appends to the kernel store; the beat marked last closes
// the kernel, and the next coefficient starts a new one. A sample beat (operation 1) gives
// one result for the loaded kernel length L (1 to 32; an empty kernel gives 0): one tap is
// read from each store and fed to a single multiply-accumulate unit per cycle, followed by
// the read, product and accumulate registers and then the output register. A sample marked
// last then gives L-1 further tail results, each from another such pass, the final one
// carrying last_res, and the delay line is cleared. The block takes no new beat while a
// sample's results are being worked out, but does take one while the last result still
// waits in the output register. No clearing pass is needed after reset.
module linear_convolution_stream_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [0:0]                          operation,
  input  logic signed [lcs_pkg::DATA_W-1:0]   value,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lcs_pkg::ACC_W-1:0]    result,
  output logic                                last_res
);

  logic                               k_we;
  logic [lcs_pkg::TAP_AW-1:0]         k_waddr;
  logic [lcs_pkg::TAP_AW-1:0]         k_raddr;
  logic [lcs_pkg::DATA_W-1:0]         k_rdata;
  logic                               d_we;
  logic [lcs_pkg::TAP_AW-1:0]         d_waddr;
  logic [lcs_pkg::TAP_AW-1:0]         d_raddr;
  logic [lcs_pkg::DATA_W-1:0]         d_rdata;
  lcs_pkg::mac_cmd_t                  cmd;
  logic                               mac_done;
  logic signed [lcs_pkg::ACC_W-1:0]   mac_sum;

  lcs_ram #(
    .WIDTH (lcs_pkg::DATA_W),
    .DEPTH (lcs_pkg::MAX_TAPS)
  ) u_kernel (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (value),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  lcs_ram #(
    .WIDTH (lcs_pkg::DATA_W),
    .DEPTH (lcs_pkg::MAX_TAPS)
  ) u_delay (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (value),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  lcs_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .coef (signed'(k_rdata)),
    .samp (signed'(d_rdata)),
    .done (mac_done),
    .sum  (mac_sum)
  );

  lcs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .last_res  (last_res),
    .k_we      (k_we),
    .k_waddr   (k_waddr),
    .k_raddr   (k_raddr),
    .d_we      (d_we),
    .d_waddr   (d_waddr),
    .d_raddr   (d_raddr),
    .cmd       (cmd),
    .mac_done  (mac_done),
    .mac_sum   (mac_sum)
  );

endmodule

[rtl/lcs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lcs_mac.sv]
// Pipelined multiply-accumulate unit fed by the kernel and delay-line reads.
module lcs_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  lcs_pkg::mac_cmd_t                   cmd,
  input  logic signed [lcs_pkg::DATA_W-1:0]   coef,
  input  logic signed [lcs_pkg::DATA_W-1:0]   samp,
  output logic                                done,
  output logic signed [lcs_pkg::ACC_W-1:0]    sum
);

  lcs_pkg::mac_cmd_t                     p1;
  lcs_pkg::mac_cmd_t                     p2;
  logic signed [lcs_pkg::PROD_W-1:0]     prod;
  logic signed [lcs_pkg::ACC_W-1:0]      acc;
  logic signed [lcs_pkg::ACC_W-1:0]      prod_ext;

  assign prod_ext = {{(lcs_pkg::ACC_W - lcs_pkg::PROD_W){prod[lcs_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1   <= '0;
      p2   <= '0;
      done <= 1'b0;
    end else begin
      p1   <= cmd;
      p2   <= p1;
      done <= p2.issue & p2.last_tap;
    end
    if (p1.zero) begin
      prod <= '0;
    end else begin
      prod <= coef * samp;
    end
    if (p2.issue) begin
      acc <= (p2.first ? '0 : acc) + prod_ext;
    end
  end

  assign sum = acc;

endmodule

[rtl/lcs_seq.sv]
// Sequencer: kernel and delay-line bookkeeping, tap issue, tail generation, output beat.
module lcs_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [0:0]                          operation,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lcs_pkg::ACC_W-1:0]    result,
  output logic                                last_res,
  output logic                                k_we,
  output logic [lcs_pkg::TAP_AW-1:0]          k_waddr,
  output logic [lcs_pkg::TAP_AW-1:0]          k_raddr,
  output logic                                d_we,
  output logic [lcs_pkg::TAP_AW-1:0]          d_waddr,
  output logic [lcs_pkg::TAP_AW-1:0]          d_raddr,
  output lcs_pkg::mac_cmd_t                   cmd,
  input  logic                                mac_done,
  input  logic signed [lcs_pkg::ACC_W-1:0]    mac_sum
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t                       state;
  logic [lcs_pkg::TAP_AW-1:0]   wp;
  logic [lcs_pkg::MAX_TAPS-1:0] vbits;
  logic [lcs_pkg::LEN_W-1:0]    klen;
  logic                         kclosed;
  logic [lcs_pkg::TAP_AW-1:0]   k;
  logic                         seq_last;
  logic [lcs_pkg::LEN_W-1:0]    tail;

  logic                         accept;
  logic                         is_sample;
  logic [lcs_pkg::LEN_W-1:0]    eff_len;
  logic                         room;
  logic [lcs_pkg::TAP_AW-1:0]   wp_next;
  logic                         k_end;
  logic                         emit_fire;
  logic                         final_now;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign is_sample = (operation == lcs_pkg::OP_SAMPLE);
  assign eff_len   = kclosed ? '0 : klen;
  assign room      = (eff_len < lcs_pkg::LEN_W'(lcs_pkg::MAX_TAPS));
  assign wp_next   = lcs_pkg::ptr_dec(wp);

  assign k_we    = accept & ~is_sample & room;
  assign k_waddr = eff_len[lcs_pkg::TAP_AW-1:0];
  assign d_we    = accept & is_sample;
  assign d_waddr = wp_next;

  assign k_raddr = k;
  assign d_raddr = lcs_pkg::ptr_add(wp, k);
  assign k_end   = (klen == '0) || ((lcs_pkg::LEN_W'(k) + lcs_pkg::LEN_W'(1)) == klen);

  always_comb begin
    cmd          = '0;
    cmd.issue    = (state == S_RUN);
    cmd.first    = (k == '0);
    cmd.last_tap = k_end;
    cmd.zero     = (klen == '0) || ~vbits[d_raddr];
  end

  assign emit_fire = (state == S_EMIT) & (~out_valid | ~out_stall);
  assign final_now = seq_last & ((tail + lcs_pkg::LEN_W'(1)) >= klen);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      vbits     <= '0;
      klen      <= '0;
      kclosed   <= 1'b1;
      k         <= '0;
      seq_last  <= 1'b0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_sample) begin
              wp             <= wp_next;
              vbits[wp_next] <= 1'b1;
              seq_last       <= last;
              tail           <= '0;
              k              <= '0;
              state          <= S_RUN;
            end else begin
              klen    <= room ? eff_len + lcs_pkg::LEN_W'(1) : eff_len;
              kclosed <= last;
            end
          end
        end
        S_RUN: begin
          if (k_end) begin
            state <= S_WAIT;
          end else begin
            k <= k + lcs_pkg::TAP_AW'(1);
          end
        end
        S_WAIT: begin
          if (mac_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            result    <= mac_sum;
            last_res  <= final_now;
            if (final_now) begin
              vbits <= '0;
              state <= S_IDLE;
            end else if (seq_last) begin
              wp             <= wp_next;
              vbits[wp_next] <= 1'b0;
              tail           <= tail + lcs_pkg::LEN_W'(1);
              k              <= '0;
              state          <= S_RUN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_WAIT))
    else $error("sum completed outside the wait state");

  a_klen_range: assert property (@(posedge clk) disable iff (rst)
    klen <= lcs_pkg::LEN_W'(lcs_pkg::MAX_TAPS))
    else $error("kernel length beyond tap count");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && final_now) |=> (vbits == '0) && (state == S_IDLE))
    else $error("delay line not cleared after final result");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && klen != '0) |-> (lcs_pkg::LEN_W'(k) < klen))
    else $error("tap index beyond kernel length");

endmodule

[bench/lcs_conv_checker.sv]
// Checker for the linear convolution stream: predicts every result beat and compares it.
module lcs_conv_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [0:0]                        operation,
  input  logic signed [lcs_pkg::DATA_W-1:0] value,
  input  logic                              last,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [lcs_pkg::ACC_W-1:0]  result,
  input  logic                              last_res,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    fin;
  } conv_out_t;

  conv_out_t                conv_due [$];
  logic signed [DATA_W-1:0] taps [MAX_TAPS];
  logic signed [DATA_W-1:0] hist [MAX_TAPS];
  int unsigned              tap_count;
  bit                       kernel_done;
  int                       fails_seen = 0;
  int                       due_count = 0;

  assign fail_count = fails_seen;
  assign pending    = due_count;

  function automatic logic signed [ACC_W-1:0] conv_sum();
    longint acc = 0;
    for (int k = 0; k < tap_count; k++) begin
      acc += longint'(taps[k]) * longint'(hist[k]);
    end
    return acc[ACC_W-1:0];
  endfunction

  task automatic shift_hist(input logic signed [DATA_W-1:0] v);
    for (int i = MAX_TAPS - 1; i > 0; i--) begin
      hist[i] = hist[i-1];
    end
    hist[0] = v;
  endtask

  task automatic push_sum(input logic fin);
    conv_due.push_back('{sum: conv_sum(), fin: fin});
  endtask

  task automatic take_beat(input op_t op, input logic signed [DATA_W-1:0] v, input logic fin);
    if (op == OP_LOAD) begin
      if (kernel_done) begin
        tap_count   = 0;
        kernel_done = 1'b0;
      end
      // coefficients past a full store are dropped
      if (tap_count < MAX_TAPS) begin
        taps[tap_count] = v;
        tap_count++;
      end
      if (fin) begin
        kernel_done = 1'b1;
      end
    end else begin
      shift_hist(v);
      push_sum(fin && tap_count <= 1);
      if (fin) begin
        for (int t = 1; t < tap_count; t++) begin
          shift_hist('0);
          push_sum(t + 1 == tap_count);
        end
        foreach (hist[i]) hist[i] = '0;
      end
    end
  endtask

  task automatic report(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    fails_seen++;
  endtask

  always @(posedge clk) begin : watch
    conv_out_t due;
    if (rst) begin
      tap_count   = 0;
      kernel_done = 1'b1;
      foreach (hist[i]) hist[i] = '0;
      foreach (taps[i]) taps[i] = '0;
      conv_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        take_beat(op_t'(operation), value, last);
      end
      if (out_valid && !out_stall) begin
        if (conv_due.size() == 0) begin
          report($sformatf("unexpected result beat %0d", result));
        end else begin
          due = conv_due.pop_front();
          if (result !== due.sum) begin
            report($sformatf("result %0d, expected %0d", result, due.sum));
          end
          if (last_res !== due.fin) begin
            report($sformatf("last_res %b, expected %b (result %0d)", last_res, due.fin,
                             due.sum));
          end
        end
      end
    end
    due_count = conv_due.size();
  end

endmodule

[bench/tb_linear_convolution_stream_top.sv]
// Testbench top for the linear convolution stream: clock, reset, stimulus and verdict.
module tb_linear_convolution_stream_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  localparam int IDLE_LIMIT  = 6000;
  localparam int ITEM_TARGET = 130;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [0:0]               operation;
  logic signed [DATA_W-1:0] value;
  logic                     last;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ACC_W-1:0]  result;
  logic                     last_res;
  int                       fail_count;
  int                       pending;

  bit hold_req = 1'b0;
  int burst_left = 0;
  int sent = 0;
  int idle_cycles = 0;

  linear_convolution_stream_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .last_res  (last_res)
  );

  lcs_conv_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .value      (value),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result),
    .last_res   (last_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[linear_convolution_stream_top] ERROR");
        $finish;
      end
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 30;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = '0;
      3: v = DATA_W'($signed($urandom_range(0, 64)) - 32);
      default: v = DATA_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_beat(input op_t op, input logic signed [DATA_W-1:0] v, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    last      <= fin;
    do @(posedge clk); while (in_stall);
    burst_left--;
    sent++;
  endtask

  task automatic load_kernel(input int len);
    for (int i = 0; i < len; i++) begin
      // now and then a sample lands while the kernel is still open
      if (i == len / 2 && $urandom_range(0, 5) == 0) begin
        send_beat(OP_SAMPLE, rand_value(), 1'b0);
      end
      send_beat(OP_LOAD, rand_value(), i == len - 1);
    end
  endtask

  task automatic play_samples(input int n, input bit close);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        load_kernel($urandom_range(1, 4));
      end
      send_beat(OP_SAMPLE, rand_value(), close && i == n - 1);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    burst_left = 0;
  endtask

  initial begin : stimulus
    int iter;
    int pick;
    in_valid  = 1'b0;
    operation = OP_LOAD;
    value     = '0;
    last      = 1'b0;
    rst       = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty kernel straight after reset
    send_beat(OP_SAMPLE, 16'sh7fff, 1'b0);
    send_beat(OP_SAMPLE, 16'sh8000, 1'b1);
    // single tap, most negative squared
    send_beat(OP_LOAD, 16'sh8000, 1'b1);
    send_beat(OP_SAMPLE, 16'sh8000, 1'b0);
    send_beat(OP_SAMPLE, 16'sh7fff, 1'b1);
    // sample while kernel open, then close it
    send_beat(OP_LOAD, 16'sh7fff, 1'b0);
    send_beat(OP_LOAD, 16'sh8000, 1'b0);
    send_beat(OP_SAMPLE, 16'sh0001, 1'b0);
    send_beat(OP_LOAD, 16'sh0005, 1'b1);
    send_beat(OP_SAMPLE, 16'sh8000, 1'b0);
    send_beat(OP_SAMPLE, 16'sh7fff, 1'b0);
    // reload mid-sequence keeps the delay line
    send_beat(OP_LOAD, -16'sd1, 1'b1);
    send_beat(OP_SAMPLE, 16'sh5555, 1'b0);
    send_beat(OP_SAMPLE, 16'sh8000, 1'b1);
    // three taps, tails
    send_beat(OP_LOAD, 16'sh7fff, 1'b0);
    send_beat(OP_LOAD, 16'sh7fff, 1'b0);
    send_beat(OP_LOAD, 16'sh7fff, 1'b1);
    send_beat(OP_SAMPLE, 16'sh8000, 1'b1);
    send_beat(OP_SAMPLE, 16'sh7fff, 1'b1);

    iter = 0;
    while (sent < ITEM_TARGET) begin
      if (iter == 3) begin
        hold_req   = 1'b1;
        burst_left = 60;
      end
      if (iter == 8) begin
        drain();
      end
      pick = $urandom_range(0, 9);
      if (iter == 0) begin
        // overfull kernel: extra coefficients are dropped
        load_kernel(34);
        play_samples(3, 1'b1);
      end else if (pick < 2) begin
        repeat ($urandom_range(1, 3)) begin
          send_beat(op_t'($urandom_range(0, 1)), rand_value(), 1'($urandom_range(0, 1)));
        end
      end else begin
        if ($urandom_range(0, 4) < 2) begin
          load_kernel(($urandom_range(0, 11) == 0) ? $urandom_range(30, 34)
                                                    : $urandom_range(1, 6));
        end
        play_samples($urandom_range(1, 10), $urandom_range(0, 7) != 0);
      end
      iter++;
    end

    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("[linear_convolution_stream_top] OK");
    end else begin
      $display("[linear_convolution_stream_top] ERROR");
    end
    $finish;
  end

endmodule

[linear_convolution_stream_top.f]
rtl/lcs_pkg.sv
rtl/lcs_ram.sv
rtl/lcs_mac.sv
rtl/lcs_seq.sv
rtl/linear_convolution_stream_top.sv
bench/lcs_conv_checker.sv
bench/tb_linear_convolution_stream_top.sv
